FILE: rtl/bcd_clock_with_stopwatch_defines.svh
// Assertion macros shared by the clock/stopwatch RTL.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef BCD_CLOCK_WITH_STOPWATCH_DEFINES_SVH
`define BCD_CLOCK_WITH_STOPWATCH_DEFINES_SVH

// same-cycle implication
`define BCS_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BCS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bcs_pkg.sv
// Shared types, codes, constants and helper functions for the BCD clock/stopwatch.
// No dependencies.
package bcs_pkg;

	localparam int MINUTE_COUNT_BITS_DEF = 8;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;
	localparam int PRESET_W    = 8;

	localparam logic REG_IDX_MINUTE_PRESET = 1'b0;

	// m/60 as (m*MUL)>>SHIFT, exact for m < 2**16
	localparam int unsigned MIN_DIV60_MUL   = 34953;
	localparam int unsigned MIN_DIV60_SHIFT = 21;
	// q/10 as (q*MUL)>>SHIFT, exact for q < 1093
	localparam int unsigned HR_DIV10_MUL    = 6554;
	localparam int unsigned HR_DIV10_SHIFT  = 16;
	localparam int unsigned SECS_PER_MIN    = 60;
	localparam int unsigned DIGIT_BASE      = 10;

	typedef logic [3:0] digit_t;
	typedef digit_t [0:5] six_digits_t;   // hour tens .. second units

	typedef enum logic [2:0] {
		OP_TICK     = 3'd0,
		OP_LOAD     = 3'd1,
		OP_SET_MODE = 3'd2,
		OP_START    = 3'd3,
		OP_PAUSE    = 3'd4,
		OP_STOP     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		MODE_CLOCK = 2'd0,
		MODE_UP    = 2'd1,
		MODE_DOWN  = 2'd2,
		MODE_OTHER = 2'd3
	} mode_t;

	typedef struct packed {
		op_t         op;
		mode_t       new_mode;
		six_digits_t load;
	} cmd_t;

	// state visible to the display path after one transaction
	typedef struct packed {
		six_digits_t clk;
		digit_t      ws_tens;
		digit_t      ws_units;
		mode_t       mode;
		logic        run;
	} snap_t;

	typedef struct packed {
		mode_t mode;
		logic  run;
		logic  clr_pend;
	} core_st_t;

	typedef struct packed {
		six_digits_t shown;
		mode_t       mode;
		logic        run;
	} res_t;

	typedef struct packed {
		digit_t tens;
		digit_t units;
		logic   carry;
	} wsec_t;

	typedef logic [63:0][3:0]  tbl64_t;
	typedef logic [127:0][3:0] tbl128_t;

	function automatic tbl64_t build_div10_64();
		tbl64_t tb;
		int     cnt;
		int     quo;
		cnt = 0;
		quo = 0;
		for (int i = 0; i < 64; i++) begin
			tb[i] = 4'(quo);
			cnt++;
			if (cnt == 10) begin
				cnt = 0;
				quo++;
			end
		end
		return tb;
	endfunction

	function automatic tbl64_t build_mod10_64();
		tbl64_t tb;
		int     cnt;
		cnt = 0;
		for (int i = 0; i < 64; i++) begin
			tb[i] = 4'(cnt);
			cnt = (cnt == 9) ? 0 : cnt + 1;
		end
		return tb;
	endfunction

	function automatic tbl128_t build_mod10_128();
		tbl128_t tb;
		int      cnt;
		cnt = 0;
		for (int i = 0; i < 128; i++) begin
			tb[i] = 4'(cnt);
			cnt = (cnt == 9) ? 0 : cnt + 1;
		end
		return tb;
	endfunction

	localparam tbl64_t  DIV10_64  = build_div10_64();
	localparam tbl64_t  MOD10_64  = build_mod10_64();
	localparam tbl128_t MOD10_128 = build_mod10_128();

	// one-second advance of the 12-hour clock; out-of-range digits carry
	function automatic six_digits_t clock_adv(six_digits_t d);
		logic [4:0]  d0, d1, d2, d3, d4, d5;
		six_digits_t r;
		d0 = {1'b0, d[0]};
		d1 = {1'b0, d[1]};
		d2 = {1'b0, d[2]};
		d3 = {1'b0, d[3]};
		d4 = {1'b0, d[4]};
		d5 = {1'b0, d[5]};
		if (d5 <= 5'd9) d5 = d5 + 5'd1;
		if (d5 > 5'd9) begin
			d4 = d4 + 5'd1;
			d5 = 5'd0;
		end
		if (d4 > 5'd5) begin
			d3 = d3 + 5'd1;
			d4 = 5'd0;
		end
		if (d3 > 5'd9) begin
			d2 = d2 + 5'd1;
			d3 = 5'd0;
		end
		if (d2 > 5'd5) begin
			d1 = d1 + 5'd1;
			d2 = 5'd0;
		end
		if (d1 > 5'd9 && d0 < 5'd1) begin
			d1 = 5'd0;
			d0 = d0 + 5'd1;
		end else if (d1 > 5'd2 && d0 == 5'd1) begin
			d1 = 5'd1;
			d0 = d0 + 5'd1;
		end
		if (d0 > 5'd1) d0 = 5'd0;
		r[0] = d0[3:0];
		r[1] = d1[3:0];
		r[2] = d2[3:0];
		r[3] = d3[3:0];
		r[4] = d4[3:0];
		r[5] = d5[3:0];
		return r;
	endfunction

	// stopwatch seconds advance; carry marks a full minute
	function automatic wsec_t wsec_adv(digit_t tens, digit_t units);
		logic [4:0] t5, u5;
		wsec_t      r;
		t5 = {1'b0, tens};
		u5 = {1'b0, units} + 5'd1;
		r.carry = 1'b0;
		if (u5 > 5'd9) begin
			u5 = 5'd0;
			t5 = t5 + 5'd1;
		end
		if (t5 > 5'd5) begin
			t5 = 5'd0;
			r.carry = 1'b1;
		end
		r.tens  = t5[3:0];
		r.units = u5[3:0];
		return r;
	endfunction

endpackage

FILE: rtl/bcs_core.sv
// Command decode and state registers of the clock and stopwatch.
// Depends on bcs_pkg; feeds the next-state snapshot to bcs_disp.
module bcs_core #(
	parameter int MINUTE_COUNT_BITS = bcs_pkg::MINUTE_COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  bcs_pkg::cmd_t                   cmd,
	input  logic [bcs_pkg::PRESET_W-1:0]    preset,
	output bcs_pkg::snap_t                  snap_nxt,
	output logic [MINUTE_COUNT_BITS-1:0]    min_nxt,
	output bcs_pkg::core_st_t               st
);
	import bcs_pkg::*;

	localparam int N     = MINUTE_COUNT_BITS;
	localparam int CMP_W = (N > PRESET_W) ? N : PRESET_W;

	six_digits_t  clk_q, clk_n;
	digit_t       wst_q, wst_n, wsu_q, wsu_n;
	logic [N-1:0] wmin_q, wmin_n;
	logic [N-1:0] up_q, up_n;
	logic [N-1:0] down_q, down_n;
	mode_t        mode_q, mode_n;
	logic         run_q, run_n;
	logic         clr_q, clr_n;
	logic         stop;
	wsec_t        ws;
	logic [CMP_W-1:0] preset_ext;

	assign preset_ext = CMP_W'(preset);

	always_comb begin
		clk_n  = clk_q;
		wst_n  = wst_q;
		wsu_n  = wsu_q;
		wmin_n = wmin_q;
		up_n   = up_q;
		down_n = down_q;
		mode_n = mode_q;
		run_n  = run_q;
		clr_n  = clr_q;
		stop   = 1'b0;
		ws     = wsec_adv(wst_q, wsu_q);

		unique case (cmd.op)
			OP_TICK: begin
				clk_n = clock_adv(clk_q);
				if (run_q) begin
					case (mode_q)
						MODE_UP: begin
							wst_n  = ws.tens;
							wsu_n  = ws.units;
							up_n   = up_q + N'(ws.carry);
							wmin_n = up_n;
							if (preset_ext == CMP_W'(up_n)) stop = 1'b1;
						end
						MODE_DOWN: begin
							if (down_q != '0) begin
								wmin_n = down_q;
								wst_n  = ws.tens;
								wsu_n  = ws.units;
								if (ws.carry) down_n = down_q - N'(1);
							end else begin
								stop = 1'b1;
							end
						end
						default: mode_n = MODE_CLOCK;
					endcase
				end
			end
			OP_LOAD:     clk_n  = cmd.load;
			OP_SET_MODE: mode_n = cmd.new_mode;
			OP_START:    run_n  = 1'b1;
			OP_PAUSE:    run_n  = 1'b0;
			OP_STOP:     stop   = 1'b1;
			default: ;
		endcase

		if (stop) begin
			run_n  = 1'b0;
			clr_n  = 1'b1;
			down_n = preset_ext[N-1:0];
			up_n   = '0;
			mode_n = MODE_CLOCK;
		end

		// pending digit clear runs at the end of a tick
		if (cmd.op == OP_TICK && clr_n) begin
			wst_n  = '0;
			wsu_n  = '0;
			wmin_n = '0;
			run_n  = 1'b0;
			clr_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_q  <= '0;
			wst_q  <= '0;
			wsu_q  <= '0;
			wmin_q <= '0;
			up_q   <= '0;
			down_q <= '0;
			mode_q <= MODE_CLOCK;
			run_q  <= 1'b0;
			clr_q  <= 1'b1;
		end else if (accept) begin
			clk_q  <= clk_n;
			wst_q  <= wst_n;
			wsu_q  <= wsu_n;
			wmin_q <= wmin_n;
			up_q   <= up_n;
			down_q <= down_n;
			mode_q <= mode_n;
			run_q  <= run_n;
			clr_q  <= clr_n;
		end
	end

	assign snap_nxt.clk      = clk_n;
	assign snap_nxt.ws_tens  = wst_n;
	assign snap_nxt.ws_units = wsu_n;
	assign snap_nxt.mode     = mode_n;
	assign snap_nxt.run      = run_n;
	assign min_nxt           = wmin_n;

	assign st.mode     = mode_q;
	assign st.run      = run_q;
	assign st.clr_pend = clr_q;

endmodule

FILE: rtl/bcs_disp.sv
// Result pipeline: minute count to BCD hour/minute digits, mode select, output register.
// Depends on bcs_pkg; takes its snapshot from bcs_core.
module bcs_disp #(
	parameter int MINUTE_COUNT_BITS = bcs_pkg::MINUTE_COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  bcs_pkg::snap_t               snap_nxt,
	input  logic [MINUTE_COUNT_BITS-1:0] min_nxt,
	output logic                         out_valid,
	input  logic                         out_ready,
	output bcs_pkg::res_t                res
);
	import bcs_pkg::*;

	localparam int N  = MINUTE_COUNT_BITS;
	localparam int QW = N - 5;      // width of minutes/60

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic adv1, adv2, adv3, adv4;

	snap_t         snap_s1, snap_s2, snap_s3;
	logic [N+15:0] p1_s1;
	logic [N-1:0]  m_s1;
	logic [QW-1:0] q_s2, q_s3;
	logic [5:0]    r_s2;
	logic [QW+12:0] p2_s3;
	digit_t        mt_s3, mu_s3;
	res_t          res_s4;

	logic [QW-1:0]  q_c;
	logic [N-1:0]   rem_c;
	logic [6:0]     t_c;
	logic [QW+3:0]  hu_c;
	digit_t         ht_c;
	res_t           res_c;

	// stall chain: a stage loads when empty or when its successor moves
	assign adv4     = !v4_s4 || out_ready;
	assign adv3     = !v3_s3 || adv4;
	assign adv2     = !v2_s2 || adv3;
	assign adv1     = !v1_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (adv1) v1_s1 <= in_valid;
			if (adv2) v2_s2 <= v1_s1;
			if (adv3) v3_s3 <= v2_s2;
			if (adv4) v4_s4 <= v3_s3;
		end
	end

	assign q_c   = QW'(p1_s1 >> MIN_DIV60_SHIFT);
	assign rem_c = m_s1 - N'(q_c) * N'(SECS_PER_MIN);

	assign t_c  = 7'(p2_s3 >> HR_DIV10_SHIFT);
	assign hu_c = (QW+4)'(q_s3) - (QW+4)'(t_c) * (QW+4)'(DIGIT_BASE);
	assign ht_c = MOD10_128[t_c];

	always_comb begin
		res_c.mode = snap_s3.mode;
		res_c.run  = snap_s3.run;
		case (snap_s3.mode)
			MODE_CLOCK: res_c.shown = snap_s3.clk;
			MODE_UP, MODE_DOWN: begin
				res_c.shown[0] = ht_c;
				res_c.shown[1] = hu_c[3:0];
				res_c.shown[2] = mt_s3;
				res_c.shown[3] = mu_s3;
				res_c.shown[4] = snap_s3.ws_tens;
				res_c.shown[5] = snap_s3.ws_units;
			end
			default: res_c.shown = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			snap_s1 <= snap_nxt;
			m_s1    <= min_nxt;
			p1_s1   <= (N+16)'(min_nxt) * (N+16)'(MIN_DIV60_MUL);
		end
		if (adv2) begin
			snap_s2 <= snap_s1;
			q_s2    <= q_c;
			r_s2    <= rem_c[5:0];
		end
		if (adv3) begin
			snap_s3 <= snap_s2;
			q_s3    <= q_s2;
			p2_s3   <= (QW+13)'(q_s2) * (QW+13)'(HR_DIV10_MUL);
			mt_s3   <= DIV10_64[r_s2];
			mu_s3   <= MOD10_64[r_s2];
		end
		if (adv4) begin
			res_s4 <= res_c;
		end
	end

	assign out_valid = v4_s4;
	assign res       = res_s4;

endmodule

FILE: rtl/bcd_clock_with_stopwatch.sv
// BCD 12-hour clock with up/down stopwatch: top level, APB register, stream ports.
// Path from input transaction to result valid: state update into stage 1,
// minutes-to-digits conversion over stages 2 and 3, digit select into the output register.
// Throughput: one transaction per cycle; s_tready drops only while all four stages are full.
// Reset: arst_n clears all but pipeline data at once; the stopwatch digit clear is pending.
// Depends on bcs_pkg, bcs_core, bcs_disp and bcd_clock_with_stopwatch_defines.svh.
`include "bcd_clock_with_stopwatch_defines.svh"

module bcd_clock_with_stopwatch #(
	parameter int MINUTE_COUNT_BITS = bcs_pkg::MINUTE_COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [1:0] new_mode, [2] load_hour_tens, [6:3] load_hour_units,
	// [9:7] load_minute_tens, [13:10] load_minute_units,
	// [16:14] load_second_tens, [20:17] load_second_units, [23:21] zero
	input  logic [bcs_pkg::IN_TDATA_W-1:0]   s_tdata,
	// [2:0] operation
	input  logic [2:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [3:0] shown_hour_tens, [7:4] shown_hour_units, [11:8] shown_minute_tens,
	// [15:12] shown_minute_units, [19:16] shown_second_tens,
	// [23:20] shown_second_units, [24] running, [31:25] zero
	output logic [bcs_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// [1:0] current_mode
	output logic [1:0]                       m_tuser,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [bcs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [bcs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [bcs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import bcs_pkg::*;

	logic                         accept;
	cmd_t                         cmd;
	logic [PRESET_W-1:0]          preset_q;
	snap_t                        snap_nxt;
	logic [MINUTE_COUNT_BITS-1:0] min_nxt;
	core_st_t                     st;
	res_t                         res;
	logic                         reg_sel;

	// config register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_ADDR_W-1] == REG_IDX_MINUTE_PRESET);
	assign prdata  = reg_sel ? APB_DATA_W'(preset_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			preset_q <= '0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			preset_q <= pwdata[PRESET_W-1:0];
		end
	end

	assign accept       = s_tvalid && s_tready;
	assign cmd.op       = op_t'(s_tuser);
	assign cmd.new_mode = mode_t'(s_tdata[1:0]);
	assign cmd.load[0]  = 4'(s_tdata[2]);
	assign cmd.load[1]  = s_tdata[6:3];
	assign cmd.load[2]  = 4'(s_tdata[9:7]);
	assign cmd.load[3]  = s_tdata[13:10];
	assign cmd.load[4]  = 4'(s_tdata[16:14]);
	assign cmd.load[5]  = s_tdata[20:17];

	bcs_core #(
		.MINUTE_COUNT_BITS(MINUTE_COUNT_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.cmd      (cmd),
		.preset   (preset_q),
		.snap_nxt (snap_nxt),
		.min_nxt  (min_nxt),
		.st       (st)
	);

	bcs_disp #(
		.MINUTE_COUNT_BITS(MINUTE_COUNT_BITS)
	) u_disp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.snap_nxt  (snap_nxt),
		.min_nxt   (min_nxt),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {7'b0, res.run, res.shown[5], res.shown[4], res.shown[3],
		res.shown[2], res.shown[1], res.shown[0]};
	assign m_tuser = res.mode;

	`BCS_ASSERT_NEXT(a_stop_halts, accept && cmd.op == OP_STOP, !st.run && st.mode == MODE_CLOCK && st.clr_pend, "stop did not halt the stopwatch")
	`BCS_ASSERT_NEXT(a_start_runs, accept && cmd.op == OP_START, st.run, "start did not set the run flag")
	`BCS_ASSERT_IMPL(a_other_blank, m_tvalid && m_tuser == MODE_OTHER, m_tdata[23:0] == '0, "digits not blank in other mode")

endmodule

FILE: bench/tb_bcd_clock_with_stopwatch.sv
// Self-checking bench for bcd_clock_with_stopwatch: stream commands in, display words out.
// An in-bench model predicts every display word; APB writes sweep the minute preset.
// Depends on bcs_pkg and the RTL top level only.
module tb_bcd_clock_with_stopwatch;
	timeunit 1ns;
	timeprecision 1ps;
	import bcs_pkg::*;

	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam logic [APB_ADDR_W-1:0] PRESET_ADDR = APB_ADDR_W'(4 * REG_IDX_MINUTE_PRESET);
	localparam int PHASE_ITEMS = 40;

	// model of the clock/stopwatch plus the queue of display words it predicts
	class clock_watch_scoreboard;
		bit [7:0]    preset;
		int unsigned clk_d[6];
		int unsigned ws[2];
		int unsigned wmh[4];
		bit [7:0]    up_cnt;
		bit [7:0]    down_left;
		bit [1:0]    mode_now;
		bit          run;
		bit          clr_pend = 1'b1;
		res_t        expected_displays[$];
		int          errors;

		function void show_minutes(int unsigned m);
			wmh[0] = (m / 600) % 10;
			wmh[1] = (m / 60) % 10;
			wmh[2] = (m % 60) / 10;
			wmh[3] = (m % 60) % 10;
		endfunction

		function void halt();
			run       = 1'b0;
			clr_pend  = 1'b1;
			down_left = preset;
			up_cnt    = '0;
			mode_now  = MODE_CLOCK;
		endfunction

		// returns 1 on a full minute
		function bit watch_second();
			ws[1]++;
			if (ws[1] > 9) begin
				ws[1] = 0;
				ws[0]++;
			end
			if (ws[0] > 5) begin
				ws[0] = 0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void advance();
			if (clk_d[5] <= 9) clk_d[5]++;
			if (clk_d[5] > 9) begin
				clk_d[4]++;
				clk_d[5] = 0;
			end
			if (clk_d[4] > 5) begin
				clk_d[3]++;
				clk_d[4] = 0;
			end
			if (clk_d[3] > 9) begin
				clk_d[2]++;
				clk_d[3] = 0;
			end
			if (clk_d[2] > 5) begin
				clk_d[1]++;
				clk_d[2] = 0;
			end
			if (clk_d[1] > 9 && clk_d[0] < 1) begin
				clk_d[1] = 0;
				clk_d[0]++;
			end else if (clk_d[1] > 2 && clk_d[0] == 1) begin
				clk_d[1] = 1;
				clk_d[0]++;
			end
			if (clk_d[0] > 1) clk_d[0] = 0;
			if (run) begin
				if (mode_now == MODE_UP) begin
					if (watch_second()) up_cnt = up_cnt + 8'd1;
					show_minutes(up_cnt);
					if (preset == up_cnt) halt();
				end else if (mode_now == MODE_DOWN) begin
					if (down_left > 0) begin
						show_minutes(down_left);
						if (watch_second()) down_left = down_left - 8'd1;
					end else begin
						halt();
					end
				end else begin
					mode_now = MODE_CLOCK;
				end
			end
			if (clr_pend) begin
				ws[0] = 0;
				ws[1] = 0;
				show_minutes(0);
				run      = 1'b0;
				clr_pend = 1'b0;
			end
		endfunction

		function void note_command(logic [2:0] op, logic [23:0] data);
			res_t        e;
			int unsigned v;
			case (op)
				OP_TICK: advance();
				OP_LOAD: begin
					clk_d[0] = data[2];
					clk_d[1] = data[6:3];
					clk_d[2] = data[9:7];
					clk_d[3] = data[13:10];
					clk_d[4] = data[16:14];
					clk_d[5] = data[20:17];
				end
				OP_SET_MODE: mode_now = data[1:0];
				OP_START: run = 1'b1;
				OP_PAUSE: run = 1'b0;
				OP_STOP: halt();
				default: ;
			endcase
			for (int i = 0; i < 6; i++) begin
				v = 0;
				if (mode_now == MODE_CLOCK)
					v = clk_d[i];
				else if (mode_now == MODE_UP || mode_now == MODE_DOWN)
					v = (i < 4) ? wmh[i] : ws[i - 4];
				e.shown[i] = 4'(v);
			end
			e.mode = mode_t'(mode_now);
			e.run  = run;
			expected_displays.push_back(e);
		endfunction

		function void check_display(res_t got);
			res_t e;
			if (expected_displays.size() == 0) begin
				errors++;
				$display("%0t: unexpected display word, expected none, actual %h", $time, got);
				return;
			end
			e = expected_displays.pop_front();
			for (int i = 0; i < 6; i++)
				if (got.shown[i] !== e.shown[i]) begin
					errors++;
					$display("%0t: digit %0d expected %h actual %h", $time, i,
						e.shown[i], got.shown[i]);
				end
			if (got.mode !== e.mode) begin
				errors++;
				$display("%0t: mode expected %0d actual %0d", $time, e.mode, got.mode);
			end
			if (got.run !== e.run) begin
				errors++;
				$display("%0t: running expected %b actual %b", $time, e.run, got.run);
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic [2:0]            s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [1:0]            m_tuser;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	clock_watch_scoreboard board;
	bit calm;   // no idling on either side
	int sent;

	bcd_clock_with_stopwatch i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic logic [23:0] rand_data();
		return {3'b000, 21'($urandom)};
	endfunction

	function automatic logic [23:0] pack_load(logic ht, logic [3:0] hu, logic [2:0] mt,
		logic [3:0] mu, logic [2:0] st, logic [3:0] su);
		return {3'b000, su, st, mu, mt, hu, ht, 2'b00};
	endfunction

	function automatic logic [23:0] mode_data(logic [1:0] m);
		logic [23:0] d;
		d = rand_data();
		d[1:0] = m;
		return d;
	endfunction

	// entered and left at a falling edge
	task automatic send_item(input logic [2:0] op, input logic [23:0] data);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		repeat (gap) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		board.note_command(op, data);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (board.expected_displays.size() != 0) @(negedge clk);
	endtask

	task automatic write_preset(input logic [7:0] value);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PRESET_ADDR;
		pwdata  <= {24'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.preset = value;
		@(negedge clk);
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[7:0] !== value) begin
			board.errors++;
			$display("%0t: preset readback expected %h actual %h", $time, value, prdata[7:0]);
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// any command with random content; loads are half near a rollover
	task automatic send_noise();
		logic [2:0] op;
		logic       ht;
		op = 3'($urandom_range(0, 7));
		ht = 1'($urandom_range(0, 1));
		if (op == OP_LOAD && $urandom_range(0, 1) == 1)
			send_item(op, pack_load(ht, ht ? 4'($urandom_range(0, 2)) : 4'($urandom_range(1, 9)),
				3'd5, 4'd9, 3'd5, 4'($urandom_range(0, 9))));
		else
			send_item(op, rand_data());
	endtask

	// stop (mostly), clearing tick, pick a mode (mostly a stopwatch one), start, then mostly ticks
	task automatic run_session();
		int         ticks;
		logic [1:0] m;
		ticks = $urandom_range(5, 130);
		if ($urandom_range(0, 7) == 0)
			m = 2'($urandom_range(0, 3));
		else
			m = ($urandom_range(0, 1) == 1) ? MODE_UP : MODE_DOWN;
		if ($urandom_range(0, 3) != 0) send_item(OP_STOP, rand_data());
		send_item(OP_TICK, rand_data());
		send_item(OP_SET_MODE, mode_data(m));
		send_item(OP_START, rand_data());
		repeat (ticks) begin
			if ($urandom_range(0, 9) == 0) send_noise();
			else send_item(OP_TICK, rand_data());
		end
		if ($urandom_range(0, 3) == 0) wait_idle();
	endtask

	// display side
	initial begin
		res_t got;
		int   stall;
		m_tready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				m_tready <= 1'b0;
				stall--;
			end else begin
				m_tready <= 1'b1;
			end
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				for (int i = 0; i < 6; i++) got.shown[i] = m_tdata[4*i +: 4];
				got.run  = m_tdata[24];
				got.mode = mode_t'(m_tuser);
				board.check_display(got);
				stall = calm ? 0 : $urandom_range(0, 3);
			end
		end
	end

	initial begin
		logic [7:0] presets[5];
		int         first;
		board = new();
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		calm     = 1'b0;
		sent     = 0;
		arst_n   = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		write_preset(8'd0);
		send_item(OP_SPARE_LO, 24'h1F_FFFF);
		send_item(OP_SET_MODE, mode_data(MODE_UP));
		// start before the first tick is cancelled by the pending clear
		send_item(OP_START, rand_data());
		send_item(OP_TICK, rand_data());
		send_item(OP_SET_MODE, mode_data(MODE_CLOCK));
		send_item(OP_LOAD, pack_load(1'b1, 4'd2, 3'd5, 4'd9, 3'd5, 4'd9));
		send_item(OP_TICK, rand_data());
		// out-of-range digits shown as loaded, carried on the next ticks
		send_item(OP_LOAD, pack_load(1'b1, 4'd15, 3'd7, 4'd15, 3'd7, 4'd15));
		send_item(OP_TICK, rand_data());
		send_item(OP_TICK, rand_data());
		send_item(OP_LOAD, pack_load(1'b0, 4'd0, 3'd0, 4'd0, 3'd0, 4'd0));
		// running in the spare mode falls back to clock
		send_item(OP_SET_MODE, mode_data(MODE_OTHER));
		send_item(OP_START, rand_data());
		send_item(OP_TICK, rand_data());
		send_item(OP_PAUSE, rand_data());
		// countdown with nothing left stops at once
		send_item(OP_SET_MODE, mode_data(MODE_DOWN));
		send_item(OP_START, rand_data());
		send_item(OP_TICK, rand_data());
		send_item(OP_TICK, rand_data());
		// up count meets a zero preset on the first tick
		send_item(OP_SET_MODE, mode_data(MODE_UP));
		send_item(OP_START, rand_data());
		send_item(OP_TICK, rand_data());
		send_item(OP_STOP, rand_data());
		send_item(OP_SPARE_HI, 24'h1F_FFFF);
		send_item(OP_PAUSE, rand_data());

		presets = '{8'd255, 8'd1, 8'd2, 8'd0, 8'($urandom_range(0, 255))};
		for (int p = 0; p < 5; p++) begin
			write_preset(presets[p]);
			calm = (p == 2);
			first = sent;
			while (sent - first < PHASE_ITEMS) run_session();
		end
		calm = 1'b0;

		wait_idle();
		repeat (8) @(negedge clk);
		if (board.errors == 0 && board.expected_displays.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
